>>> rtl/http_request_method_classify_assert.svh
// Assertion macros used by the method classifier checker.
`ifndef HTTP_REQUEST_METHOD_CLASSIFY_ASSERT_SVH
`define HTTP_REQUEST_METHOD_CLASSIFY_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define HRMC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: label");

// Next-cycle implication, checked during reset as well.
`define HRMC_ASSERT_NEXT(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed: label");

`endif

>>> rtl/hrmc_pkg.sv
// Package: method words, method codes and the code priority function.
`timescale 1ns / 1ps
`default_nettype none
package hrmc_pkg;

   localparam int WORD_COUNT = 9;
   localparam int HIST_DEPTH = 8;
   localparam int WORD_BYTES = 9;
   localparam int WORD_DELETE = 1;
   localparam int WORD_TRACE = 8;
   localparam logic [7:0] SCAN_LIMIT_RESET = 8'd50;

   typedef logic [WORD_BYTES*8-1:0] word_chars_type;
   typedef logic [WORD_COUNT-1:0] word_flags_type;

   // Byte j (bits 8j+7:8j) holds the character j places before the word's end.
   localparam word_chars_type METHOD_WORDS [WORD_COUNT] = '{
      word_chars_type'("connect"), word_chars_type'("delete"),
      word_chars_type'("extension"), word_chars_type'("get"),
      word_chars_type'("head"), word_chars_type'("options"),
      word_chars_type'("post"), word_chars_type'("put"),
      word_chars_type'("trace")
   };
   localparam logic [3:0] METHOD_LENS [WORD_COUNT] = '{
      4'd7, 4'd6, 4'd9, 4'd3, 4'd4, 4'd7, 4'd4, 4'd3, 4'd5
   };

   typedef enum logic [3:0] {
      CODE_UNKNOWN = 4'd0,
      CODE_CONNECT = 4'd1,
      CODE_DELETE = 4'd2,
      CODE_EXTENSION = 4'd3,
      CODE_GET = 4'd4,
      CODE_HEAD = 4'd5,
      CODE_OPTIONS = 4'd6,
      CODE_POST = 4'd7,
      CODE_PUT = 4'd8,
      CODE_TRACE = 4'd9
   } method_code_type;

   // Later words except trace, then delete at start, then trace later,
   // then any start word; lowest index wins within each group.
   function automatic method_code_type pick_code(word_flags_type later,
                                                 word_flags_type start);
      method_code_type code;
      code = CODE_UNKNOWN;
      for (int b = WORD_COUNT - 1; b >= 0; b--) begin
         if (start[b]) code = method_code_type'(4'(b + 1));
      end
      if (later[WORD_TRACE]) code = CODE_TRACE;
      if (start[WORD_DELETE]) code = CODE_DELETE;
      for (int b = WORD_TRACE - 1; b >= 0; b--) begin
         if (later[b]) code = method_code_type'(4'(b + 1));
      end
      return code;
   endfunction

endpackage
`default_nettype wire

>>> rtl/hrmc_if.sv
// Channel interfaces: packet bytes, method results and the scan limit write.
`timescale 1ns / 1ps
`default_nettype none
interface hrmc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;
   modport source (output valid, data_byte, last_byte, input ready);
   modport sink (input valid, data_byte, last_byte, output ready);
endinterface

interface hrmc_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] method_code;
   modport source (output valid, method_code, input ready);
   modport sink (input valid, method_code, output ready);
endinterface

interface hrmc_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] scan_limit;
   modport source (output valid, scan_limit, input ready);
   modport sink (input valid, scan_limit, output ready);
endinterface
`default_nettype wire

>>> rtl/http_request_method_classify.sv
// Top level: HTTP request method classifier over a packet byte stream.
//
// Usage:
//  - req_ch carries one packet byte per transfer; last_byte marks the end.
//  - rsp_ch carries one method_code per packet, issued after its last byte.
//  - csr_ch writes scan_limit (bytes searched from packet start); always
//    ready, and meant to be written between packets.
// Throughput: one byte per cycle, steady state, no gaps between packets,
//  unless a last byte waits behind a stalled result. The fold is logic
//  before the input register; 9 word compares against an 8-byte history and
//  code priority are combinational between it and the result register.
// Stall: the result register holds its code until rsp_ch transfers it.
//  Bytes keep flowing meanwhile; only a further last byte waits in the input
//  register, and req_ch.ready drops only then.
// Reset: synchronous, active high. Clears all packet state, empties both
//  registers and sets scan_limit to 50. No clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
module http_request_method_classify
   import hrmc_pkg::*;
(
   input  wire         clock,
   input  wire         reset,
   hrmc_req_if.sink    req_ch,
   hrmc_rsp_if.source  rsp_ch,
   hrmc_csr_if.sink    csr_ch
);

   // scan limit register
   logic [7:0] scan_limit_ff, scan_limit_in;

   // input register (holds the folded byte)
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff, in_byte_in;
   logic       in_last_ff, in_last_in;

   // packet state
   logic [7:0]     hist_ff [HIST_DEPTH];
   logic [7:0]     hist_in [HIST_DEPTH];
   logic [7:0]     pos_ff, pos_in;
   word_flags_type start_ff, start_in;
   word_flags_type later_ff, later_in;

   // result register
   logic            rsp_valid_ff, rsp_valid_in;
   method_code_type rsp_code_ff, rsp_code_in;

   logic           advance;
   logic           req_xfer;
   logic           in_window;
   logic [8:0]     pos_plus1;
   word_flags_type hit_start, hit_later;
   word_flags_type start_next, later_next;
   logic           match;

   // A byte moves on unless it ends a packet and the result slot is blocked.
   assign advance  = in_valid_ff && (!in_last_ff || !rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;
   assign req_xfer = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.method_code = rsp_code_ff;

   // Input stage with A-Z folded to lower case.
   always_comb begin
      scan_limit_in = csr_ch.valid ? csr_ch.scan_limit : scan_limit_ff;
      in_valid_in   = req_xfer ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
      in_byte_in    = in_byte_ff;
      in_last_in    = in_last_ff;
      if (req_xfer) begin
         in_last_in = req_ch.last_byte;
         if (req_ch.data_byte >= 8'h41 && req_ch.data_byte <= 8'h5a) begin
            in_byte_in = req_ch.data_byte + 8'h20;
         end else begin
            in_byte_in = req_ch.data_byte;
         end
      end
   end

   // Word matching: each word ends at the current byte, earlier chars in history.
   assign pos_plus1 = {1'b0, pos_ff} + 9'd1;
   assign in_window = pos_ff < scan_limit_ff;

   always_comb begin
      hit_start = '0;
      hit_later = '0;
      for (int w = 0; w < WORD_COUNT; w++) begin
         match = (in_byte_ff == METHOD_WORDS[w][7:0]);
         for (int k = 0; k < HIST_DEPTH; k++) begin
            if (5'(k + 1) < {1'b0, METHOD_LENS[w]}) begin
               match = match && (hist_ff[k] == METHOD_WORDS[w][8*(k+1) +: 8]);
            end
         end
         if (in_window && match && pos_plus1 >= {5'd0, METHOD_LENS[w]}) begin
            if (pos_plus1 == {5'd0, METHOD_LENS[w]}) begin
               hit_start[w] = 1'b1;
            end else begin
               hit_later[w] = 1'b1;
            end
         end
      end
   end

   assign start_next = start_ff | hit_start;
   assign later_next = later_ff | hit_later;

   // Packet state update and result load.
   always_comb begin
      hist_in      = hist_ff;
      pos_in       = pos_ff;
      start_in     = start_ff;
      later_in     = later_ff;
      rsp_code_in  = rsp_code_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      if (advance) begin
         if (in_last_ff) begin
            // packet done: issue code, back to reset state
            rsp_code_in  = pick_code(later_next, start_next);
            rsp_valid_in = 1'b1;
            for (int k = 0; k < HIST_DEPTH; k++) begin
               hist_in[k] = '0;
            end
            pos_in   = '0;
            start_in = '0;
            later_in = '0;
         end else begin
            for (int k = HIST_DEPTH - 1; k > 0; k--) begin
               hist_in[k] = hist_ff[k-1];
            end
            hist_in[0] = in_byte_ff;
            // saturates at 255, which lies outside every window
            if (pos_ff != 8'hff) begin
               pos_in = pos_ff + 8'd1;
            end
            start_in = start_next;
            later_in = later_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_limit_ff <= SCAN_LIMIT_RESET;
         in_valid_ff   <= 1'b0;
         pos_ff        <= '0;
         start_ff      <= '0;
         later_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         for (int k = 0; k < HIST_DEPTH; k++) begin
            hist_ff[k] <= '0;
         end
      end else begin
         scan_limit_ff <= scan_limit_in;
         in_valid_ff   <= in_valid_in;
         pos_ff        <= pos_in;
         start_ff      <= start_in;
         later_ff      <= later_in;
         rsp_valid_ff  <= rsp_valid_in;
         hist_ff       <= hist_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      in_byte_ff  <= in_byte_in;
      in_last_ff  <= in_last_in;
      rsp_code_ff <= rsp_code_in;
   end

endmodule
`default_nettype wire

>>> rtl/hrmc_checker.sv
// Port checker for the method classifier, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "http_request_method_classify_assert.svh"
module hrmc_checker
   import hrmc_pkg::*;
(
   input wire       clock,
   input wire       reset,
   input wire       req_valid,
   input wire       req_ready,
   input wire       rsp_valid,
   input wire       rsp_ready,
   input wire [3:0] method_code,
   input wire       csr_ready
);

   // results stay stable while stalled
   `HRMC_ASSERT_NEXT(a_rsp_hold, clock, !reset && rsp_valid && !rsp_ready, rsp_valid && $stable(method_code))
   // code is always a defined method or unknown
   `HRMC_ASSERT_NOW(a_code_range, clock, reset, rsp_valid, method_code <= CODE_TRACE)
   // reset empties the result register
   `HRMC_ASSERT_NEXT(a_reset_empty, clock, reset, !rsp_valid)
   // input only backs up behind a stalled result
   `HRMC_ASSERT_NOW(a_req_stall_cause, clock, reset, req_valid && !req_ready, rsp_valid && !rsp_ready && csr_ready)

endmodule

bind http_request_method_classify hrmc_checker u_hrmc_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_ch.valid),
   .req_ready   (req_ch.ready),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .method_code (rsp_ch.method_code),
   .csr_ready   (csr_ch.ready)
);
`default_nettype wire
